// File: hw/rtl/bfifo_pkg.sv
// bfifo_pkg: shared constants, operation codes and control/status structs
// for the circular byte fifo with decimal reader. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfifo_pkg;

    localparam int DEPTH     = 1024;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CAP_W     = 11;
    localparam int BYTE_W    = 8;
    localparam int NUM_W     = 32;
    localparam int KIND_W    = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
    localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);

    localparam logic [BYTE_W-1:0] CHR_MINUS = 8'h2d;
    localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_NINE  = 8'h39;
    localparam logic [NUM_W-1:0]  RADIX     = 32'd10;

    // stream and register port widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = KIND_W;
    localparam int RES_W     = 1 + BYTE_W + NUM_W + IDX_W + 1;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH     = 3'd0,
        KIND_POP      = 3'd1,
        KIND_PEEK     = 3'd2,
        KIND_SKIP     = 3'd3,
        KIND_CLEAR    = 3'd4,
        KIND_READ_INT = 3'd5
    } t_kind;

    typedef struct packed {
        logic accept;
        logic exec;
        logic num_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic digit;
        logic read_int;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: hw/rtl/bfifo_ram.sv
// bfifo_ram: generic single write, single read ram with registered read data
// and write-first behaviour on an address match. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bfifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            o_rdata <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bfifo_dp.sv
// bfifo_dp: datapath with the byte store, read/write indices, capacity
// register, decimal accumulator and result register. uses bfifo_pkg, bfifo_ram.
`timescale 1ns / 1ps
`default_nettype none

module bfifo_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bfifo_pkg::t_dp_cmd            i_cmd,
    output bfifo_pkg::t_dp_sts                 o_sts,
    input  wire logic [bfifo_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [bfifo_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic                          i_cfg_we,
    input  wire logic [bfifo_pkg::CAP_W-1:0]   i_cfg_wdata,
    output logic      [bfifo_pkg::CAP_W-1:0]   o_cap,
    output logic      [bfifo_pkg::M_TDATA_W-1:0] o_res
);

    function automatic logic [bfifo_pkg::IDX_W-1:0] f_adv(
        input logic [bfifo_pkg::IDX_W-1:0] idx,
        input logic [bfifo_pkg::CAP_W-1:0] cap
    );
        logic [bfifo_pkg::CAP_W-1:0] nxt;
        nxt = bfifo_pkg::CAP_W'(idx) + bfifo_pkg::CAP_W'(1);
        return (nxt >= cap) ? '0 : nxt[bfifo_pkg::IDX_W-1:0];
    endfunction

    logic [bfifo_pkg::IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic [bfifo_pkg::IDX_W-1:0]  r_wr_idx, n_wr_idx;
    logic [bfifo_pkg::CAP_W-1:0]  r_cap;
    bfifo_pkg::t_kind             r_kind, n_kind;
    logic [bfifo_pkg::BYTE_W-1:0] r_data, n_data;
    logic                         r_ok, n_ok;
    logic [bfifo_pkg::BYTE_W-1:0] r_bout, n_bout;
    logic [bfifo_pkg::NUM_W-1:0]  r_acc, n_acc;
    logic                         r_neg, n_neg;
    logic                         r_found, n_found;
    logic [bfifo_pkg::M_TDATA_W-1:0] r_res;

    logic [bfifo_pkg::CAP_W-1:0]  eff_cap;
    logic [bfifo_pkg::IDX_W-1:0]  rd_adv;
    logic [bfifo_pkg::IDX_W-1:0]  wr_adv;
    logic                         empty;
    logic                         digit;
    logic [bfifo_pkg::BYTE_W-1:0] rdata;
    logic                         we;
    logic [bfifo_pkg::CAP_W-1:0]  fill_wide;
    logic [bfifo_pkg::NUM_W-1:0]  num_res;
    logic                         ok_res;

    bfifo_ram #(
        .WIDTH (bfifo_pkg::BYTE_W),
        .DEPTH (bfifo_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wr_idx),
        .i_wdata (r_data),
        .i_raddr (n_rd_idx),
        .o_rdata (rdata)
    );

    always_comb begin
        if (r_cap < bfifo_pkg::CAP_MIN) begin
            eff_cap = bfifo_pkg::CAP_MIN;
        end else if (r_cap > bfifo_pkg::CAP_MAX) begin
            eff_cap = bfifo_pkg::CAP_MAX;
        end else begin
            eff_cap = r_cap;
        end
    end

    assign rd_adv = f_adv(r_rd_idx, eff_cap);
    assign wr_adv = f_adv(r_wr_idx, eff_cap);
    assign empty  = (r_rd_idx == r_wr_idx);
    assign digit  = (rdata >= bfifo_pkg::CHR_ZERO) && (rdata <= bfifo_pkg::CHR_NINE);

    assign o_sts.empty    = empty;
    assign o_sts.digit    = digit;
    assign o_sts.read_int = (r_kind == bfifo_pkg::KIND_READ_INT);

    // the ram address follows the next read index, so rdata always shows the head byte
    always_comb begin
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        n_kind   = r_kind;
        n_data   = r_data;
        n_ok     = r_ok;
        n_bout   = r_bout;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_found  = r_found;
        we       = 1'b0;
        if (i_cfg_we) begin
            n_rd_idx = '0;
            n_wr_idx = '0;
        end else if (i_cmd.accept) begin
            n_kind  = bfifo_pkg::t_kind'(i_kind);
            n_data  = i_data_byte;
            n_ok    = 1'b0;
            n_bout  = '0;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_found = 1'b0;
        end else if (i_cmd.exec) begin
            case (r_kind)
                bfifo_pkg::KIND_PUSH: begin
                    if (wr_adv != r_rd_idx) begin
                        we       = 1'b1;
                        n_wr_idx = wr_adv;
                        n_ok     = 1'b1;
                    end
                end
                bfifo_pkg::KIND_POP: begin
                    if (!empty) begin
                        n_bout   = rdata;
                        n_ok     = 1'b1;
                        n_rd_idx = rd_adv;
                    end
                end
                bfifo_pkg::KIND_PEEK: begin
                    if (!empty) begin
                        n_bout = rdata;
                        n_ok   = 1'b1;
                    end
                end
                bfifo_pkg::KIND_SKIP: begin
                    if (!empty) begin
                        n_rd_idx = rd_adv;
                    end
                end
                bfifo_pkg::KIND_CLEAR: begin
                    n_rd_idx = '0;
                    n_wr_idx = '0;
                end
                bfifo_pkg::KIND_READ_INT: begin
                    // optional leading sign
                    if (!empty && (rdata == bfifo_pkg::CHR_MINUS)) begin
                        n_neg    = 1'b1;
                        n_rd_idx = rd_adv;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.num_step) begin
            // one byte a cycle; a non-digit is consumed and ends the number
            if (!empty) begin
                n_rd_idx = rd_adv;
                if (digit) begin
                    n_acc   = r_acc * bfifo_pkg::RADIX
                            + bfifo_pkg::NUM_W'(rdata - bfifo_pkg::CHR_ZERO);
                    n_found = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_wr_idx > r_rd_idx) begin
            fill_wide = bfifo_pkg::CAP_W'(r_wr_idx) - bfifo_pkg::CAP_W'(r_rd_idx);
        end else if (r_wr_idx == r_rd_idx) begin
            fill_wide = '0;
        end else begin
            fill_wide = eff_cap - bfifo_pkg::CAP_W'(r_rd_idx) + bfifo_pkg::CAP_W'(r_wr_idx);
        end
        if (r_kind == bfifo_pkg::KIND_READ_INT) begin
            ok_res  = r_found;
            num_res = !r_found ? '0 : (r_neg ? ('0 - r_acc) : r_acc);
        end else begin
            ok_res  = r_ok;
            num_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_cap    <= bfifo_pkg::CAP_RESET;
        end else begin
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_data  <= n_data;
        r_ok    <= n_ok;
        r_bout  <= n_bout;
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        r_found <= n_found;
        if (i_cmd.load_out) begin
            r_res <= {{(bfifo_pkg::M_TDATA_W - bfifo_pkg::RES_W){1'b0}},
                      empty, fill_wide[bfifo_pkg::IDX_W-1:0], num_res, r_bout, ok_res};
        end
    end

    assign o_cap = r_cap;
    assign o_res = r_res;

endmodule

`default_nettype wire

// File: hw/rtl/bfifo_ctrl.sv
// bfifo_ctrl: controller state machine sequencing each request through the
// datapath and owning the result valid flag. uses bfifo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfifo_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire bfifo_pkg::t_dp_sts i_sts,
    output bfifo_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_NUM,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.read_int && !i_sts.empty) begin
                    n_state = S_NUM;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_NUM: begin
                o_cmd.num_step = 1'b1;
                if (i_sts.empty || !i_sts.digit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait here while the previous result is still held
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: hw/rtl/byte_ring_fifo_with_decimal_read.sv
// byte_ring_fifo_with_decimal_read: top level of the circular byte fifo with
// decimal integer reader; joins bfifo_ctrl and bfifo_dp. uses bfifo_pkg.
//
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid / tready            tuser kind, tdata data_byte
//  m_axis    out  tvalid / tready            tdata result fields
//  apb       in   psel, penable, pwrite      capacity at byte address 0
//
// a request passes accept, execute and load of the result, waiting before the load
// while the previous result is held; the result is registered at the load. read_int
// walks one byte per cycle after the optional sign, with one more step when the walk
// ends on an empty fifo, as the single ram read port walks the head.
// a new request is taken once the previous one has reached the result register,
// while that result may still be waiting for m_axis_tready.
// reset is synchronous: indices clear, capacity returns to 1024, store contents
// stay undefined. a capacity write empties the fifo.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo_with_decimal_read (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] data_byte
    input  wire logic [bfifo_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] kind
    input  wire logic [bfifo_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] ok, [8:1] byte_out, [40:9] number, [50:41] fill_count, [51] empty_res
    output logic      [bfifo_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bfifo_pkg::APB_AW-1:0]     paddr,
    input  wire logic [bfifo_pkg::APB_DW-1:0]     pwdata,
    output logic      [bfifo_pkg::APB_DW-1:0]     prdata,
    output logic                                  pready
);

    bfifo_pkg::t_dp_cmd cmd;
    bfifo_pkg::t_dp_sts sts;
    logic                          cfg_we;
    logic                          reg_sel;
    logic [bfifo_pkg::CAP_W-1:0]   cap;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[bfifo_pkg::APB_AW-1:2] == bfifo_pkg::REG_CAPACITY);
    assign cfg_we  = psel && penable && pwrite && reg_sel;
    assign prdata  = reg_sel ? bfifo_pkg::APB_DW'(cap) : '0;

    bfifo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bfifo_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (s_axis_tuser),
        .i_data_byte (s_axis_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (pwdata[bfifo_pkg::CAP_W-1:0]),
        .o_cap       (cap),
        .o_res       (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: hw/rtl/bfifo_chk.sv
// bfifo_chk: port-level checker for the circular byte fifo, bound to the top
// level. uses bfifo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfifo_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [bfifo_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // empty flag agrees with fill count
    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[51] == (m_axis_tdata[50:41] == 10'd0)))
        else $error("empty flag and fill count disagree");

    // a failed request carries no byte and no number
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0]
            |-> (m_axis_tdata[8:1] == 8'd0) && (m_axis_tdata[40:9] == 32'd0))
        else $error("failed request returned data");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while one is in flight");

endmodule

bind byte_ring_fifo_with_decimal_read bfifo_chk u_bfifo_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: bench/tb.sv
// tb: self-checking bench for the circular byte fifo with decimal reader;
// predicts every result in step with the requests and checks it field by field.
// depends on bfifo_pkg and byte_ring_fifo_with_decimal_read.
`timescale 1ns / 1ps

module tb;
    import bfifo_pkg::*;

    typedef struct packed {
        logic              empty_res;
        logic [IDX_W-1:0]  fill_count;
        logic [NUM_W-1:0]  number;
        logic [BYTE_W-1:0] byte_out;
        logic              ok;
    } t_fifo_result;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] data_byte
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    // [2:0] kind
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] ok, [8:1] byte_out, [40:9] number, [50:41] fill_count, [51] empty_res
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_AW-1:0]     paddr         = '0;
    logic [APB_DW-1:0]     pwdata        = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // predicted fifo state
    logic [CAP_W-1:0]      ring_cap  = CAP_RESET;
    logic [IDX_W-1:0]      ring_head = '0;
    logic [IDX_W-1:0]      ring_tail = '0;
    logic [BYTE_W-1:0]     ring_bytes [DEPTH];

    t_fifo_result          expected_results [$];
    int unsigned           requests_sent = 0;
    int unsigned           mismatches    = 0;
    logic                  calm          = 1'b0;

    byte_ring_fifo_with_decimal_read dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned ring_slots();
        if (ring_cap < CAP_MIN) return 32'(CAP_MIN);
        if (ring_cap > CAP_MAX) return 32'(CAP_MAX);
        return 32'(ring_cap);
    endfunction

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        int unsigned n;
        n = idx + 1;
        if (n >= ring_slots()) n = 0;
        return IDX_W'(n);
    endfunction

    function automatic logic [IDX_W-1:0] held_bytes();
        if (ring_tail == ring_head) return '0;
        if (ring_tail > ring_head) return ring_tail - ring_head;
        return IDX_W'(ring_slots() - ring_head + ring_tail);
    endfunction

    function automatic t_fifo_result predict_request(input logic [KIND_W-1:0] kind,
                                                     input logic [BYTE_W-1:0] data);
        t_fifo_result      res;
        logic [IDX_W-1:0]  nxt;
        logic [BYTE_W-1:0] ch;
        logic [NUM_W-1:0]  acc;
        logic              neg;
        logic              found;
        logic              done;
        res   = '0;
        acc   = '0;
        neg   = 1'b0;
        found = 1'b0;
        done  = 1'b0;
        case (kind)
            KIND_PUSH: begin
                nxt = next_slot(ring_tail);
                if (nxt != ring_head) begin
                    ring_bytes[ring_tail] = data;
                    ring_tail = nxt;
                    res.ok = 1'b1;
                end
            end
            KIND_POP: begin
                if (ring_tail != ring_head) begin
                    res.byte_out = ring_bytes[ring_head];
                    ring_head = next_slot(ring_head);
                    res.ok = 1'b1;
                end
            end
            KIND_PEEK: begin
                if (ring_tail != ring_head) begin
                    res.byte_out = ring_bytes[ring_head];
                    res.ok = 1'b1;
                end
            end
            KIND_SKIP: begin
                if (ring_tail != ring_head) ring_head = next_slot(ring_head);
            end
            KIND_CLEAR: begin
                ring_head = '0;
                ring_tail = '0;
            end
            KIND_READ_INT: begin
                if (ring_tail != ring_head) begin
                    neg = (ring_bytes[ring_head] == CHR_MINUS);
                    if (neg) ring_head = next_slot(ring_head);
                    // the terminating non-digit is consumed as well
                    while (!done && ring_tail != ring_head) begin
                        ch = ring_bytes[ring_head];
                        ring_head = next_slot(ring_head);
                        if (ch < CHR_ZERO || ch > CHR_NINE) begin
                            done = 1'b1;
                        end else begin
                            acc = acc * RADIX + NUM_W'(ch - CHR_ZERO);
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        res.number = neg ? -acc : acc;
                        res.ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.fill_count = held_bytes();
        res.empty_res  = (ring_head == ring_tail);
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        t_fifo_result got;
        t_fifo_result want;
        got = word[RES_W-1:0];
        if (expected_results.size() == 0) begin
            report_mismatch("result with no request pending", 64'(word), 64'(0));
            return;
        end
        want = expected_results.pop_front();
        if (got.ok !== want.ok) report_mismatch("ok", 64'(got.ok), 64'(want.ok));
        if (got.byte_out !== want.byte_out)
            report_mismatch("byte_out", 64'(got.byte_out), 64'(want.byte_out));
        if (got.number !== want.number)
            report_mismatch("number", 64'(got.number), 64'(want.number));
        if (got.fill_count !== want.fill_count)
            report_mismatch("fill_count", 64'(got.fill_count), 64'(want.fill_count));
        if (got.empty_res !== want.empty_res)
            report_mismatch("empty_res", 64'(got.empty_res), 64'(want.empty_res));
        if (word[M_TDATA_W-1:RES_W] !== '0)
            report_mismatch("tdata padding", 64'(word[M_TDATA_W-1:RES_W]), 64'(0));
    endtask

    always @(negedge i_clk) m_axis_tready <= calm || ($urandom_range(99) >= 25);

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(predict_request(kind, data));
        if (kind <= KIND_READ_INT) requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        // let the bench idle before the next step
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [APB_DW-1:0] word);
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * REG_CAPACITY);
        pwdata  <= word;
        @(negedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        ring_cap  = word[CAP_W-1:0];
        ring_head = '0;
        ring_tail = '0;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_ascii(input string text);
        for (int i = 0; i < text.len(); i++) send_request(KIND_PUSH, text[i]);
    endtask

    // optional sign, up to twelve digits (so the value wraps), usually a terminator
    task automatic push_number_text();
        int unsigned       n_digits;
        logic [BYTE_W-1:0] ch;
        n_digits = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
        if ($urandom_range(1)) send_request(KIND_PUSH, CHR_MINUS);
        repeat (n_digits) send_request(KIND_PUSH, BYTE_W'(CHR_ZERO + $urandom_range(9)));
        if ($urandom_range(9) != 0) begin
            do ch = BYTE_W'($urandom_range(255)); while (ch >= CHR_ZERO && ch <= CHR_NINE);
            send_request(KIND_PUSH, ch);
        end
        send_request(KIND_READ_INT, BYTE_W'($urandom_range(255)));
    endtask

    task automatic send_random_op();
        int unsigned       r;
        logic [BYTE_W-1:0] d;
        r = $urandom_range(99);
        d = BYTE_W'($urandom_range(255));
        if (r < 40)      send_request(KIND_PUSH, d);
        else if (r < 55) send_request(KIND_POP, d);
        else if (r < 65) send_request(KIND_PEEK, d);
        else if (r < 75) send_request(KIND_SKIP, d);
        else if (r < 79) send_request(KIND_CLEAR, d);
        else if (r < 94) send_request(KIND_READ_INT, d);
        else             send_request(KIND_W'($urandom_range(6, 7)), d);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_empty_fifo();
        send_request(KIND_POP, 8'h00);
        send_request(KIND_PEEK, 8'hff);
        send_request(KIND_SKIP, 8'h00);
        send_request(KIND_READ_INT, 8'h00);
        send_request(KIND_W'(6), 8'hff);
        send_request(KIND_W'(7), 8'h00);
    endtask

    task automatic test_push_pop_extremes();
        send_request(KIND_PUSH, 8'h00);
        send_request(KIND_PUSH, 8'hff);
        send_request(KIND_PEEK, 8'h00);
        send_request(KIND_POP, 8'h00);
        send_request(KIND_POP, 8'h00);
    endtask

    task automatic test_full_ring();
        write_capacity(32'd2);
        send_request(KIND_PUSH, 8'ha5);
        send_request(KIND_PUSH, 8'h5a);
        send_request(KIND_PEEK, 8'h00);
        send_request(KIND_SKIP, 8'h00);
        send_request(KIND_POP, 8'h00);
    endtask

    task automatic test_decimal_read();
        write_capacity(32'd2047);
        push_ascii("-17x");
        send_request(KIND_READ_INT, 8'h00);
        // sign then a non-digit: both consumed, no number
        push_ascii("-+");
        send_request(KIND_READ_INT, 8'h00);
    endtask

    task automatic test_clear();
        send_request(KIND_PUSH, 8'h31);
        send_request(KIND_CLEAR, 8'h00);
    endtask

    task automatic test_random_mix();
        logic [APB_DW-1:0] cap_word;
        int unsigned       start;
        for (int p = 0; p < 9; p++) begin
            case (p)
                0:       cap_word = 32'd3;
                1:       cap_word = 32'd1024;
                2:       cap_word = 32'd0;
                3:       cap_word = 32'hffff_ffff;
                4:       cap_word = 32'd17;
                5:       cap_word = 32'd1;
                6:       cap_word = 32'd200;
                7:       cap_word = $urandom_range(2, 1024);
                default: cap_word = 32'd5;
            endcase
            write_capacity(cap_word);
            calm  = (p == 6);
            start = requests_sent;
            while (requests_sent - start < 54) begin
                if ($urandom_range(99) < 60) push_number_text();
                else send_random_op();
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        test_empty_fifo();
        test_push_pop_extremes();
        test_full_ring();
        test_decimal_read();
        test_clear();
        test_random_mix();
        wait_drained();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
